// ===== rtl/core/i2c_master_register_access_macros.svh =====
// ----------------------------------------------------------------------------
// i2c_master_register_access_macros
// Assertion macros used by the top level to check the I2C master.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CM_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, checked out of reset
`define I2CM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and reset constants shared by the I2C master modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // configuration reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd6;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

  // default depth of the request and result queues
  localparam int QUEUE_DEPTH_DEF = 2;

  // classified request kind
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // bus phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_HIGH,
    PH_ST_LOW,
    PH_TX_LO,
    PH_TX_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_RS_PREP,
    PH_RX_LO,
    PH_RX_HI,
    PH_MACK_LO,
    PH_MACK_HI,
    PH_SP_LO,
    PH_SP_HI
  } phase_t;

  // byte stage within a transaction
  typedef enum logic [1:0] {
    STG_DEV,
    STG_REG,
    STG_SECOND,
    STG_RX
  } stage_t;

  // classified request held in the request queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } item_t;

  // one result per request
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
  } result_t;

  // handshake between request queue and engine
  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests, classifies the opcode, fixes a zero read count and
// queues the request for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      opcode,
  input  logic [7:0]      dev_addr,
  input  logic [7:0]      reg_addr,
  input  logic [7:0]      write_data,
  input  logic [7:0]      read_count,
  input  logic            sda_in,
  output i2cm_pkg::item_t item,
  output i2cm_pkg::qctl_t ctl_out,
  input  logic            ctl_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  i2cm_pkg::item_t mem [QUEUE_DEPTH];
  i2cm_pkg::item_t cls;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  // classify the request
  always_comb begin
    cls.dev_addr   = dev_addr;
    cls.reg_addr   = reg_addr;
    cls.write_data = write_data;
    cls.sda_in     = sda_in;
    cls.read_count = (read_count == 8'd0) ? 8'd1 : read_count;
    case (opcode)
      i2cm_pkg::OP_WRITE: cls.cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::OP_READ:  cls.cmd = i2cm_pkg::CMD_READ;
      default:            cls.cmd = i2cm_pkg::CMD_TICK;
    endcase
  end

  assign full    = (count_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = ctl_pop && (count_r != '0);

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= cls;
    end
  end

  assign item          = mem[rd_ptr_r];
  assign ctl_out.valid = (count_r != '0);
  assign ctl_out.pop   = do_pop;

endmodule

// ===== rtl/core/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one tick per request, drives SCL/SDA and reports
// completion, abort and received bytes.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_wdata,
  input  i2cm_pkg::qctl_t   ctl_in,
  output logic              pop,
  input  i2cm_pkg::item_t   item,
  input  logic              res_full,
  output logic              res_push,
  output i2cm_pkg::result_t res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  i2cm_pkg::stage_t stage_r, stage_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        rd_r, rd_nxt;
  logic        abort_r, abort_nxt;
  logic [15:0] half_r, ackto_r;
  logic [15:0] half_eff, wait_inc;
  logic        go, done, err, rvalid, rlast;
  logic [7:0]  rbyte;
  logic        nack;

  assign go       = ctl_in.valid && !res_full;
  assign pop      = go;
  assign res_push = go;
  assign half_eff = (half_r == 16'd0) ? 16'd1 : half_r;
  assign wait_inc = (wait_r != 16'hffff) ? wait_r + 16'd1 : wait_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= i2cm_pkg::HALF_PERIOD_RST;
      ackto_r <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == i2cm_pkg::CFG_HALF_PERIOD) begin
        half_r <= cfg_wdata;
      end else begin
        ackto_r <= cfg_wdata;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    delay_nxt = delay_r;
    wait_nxt  = wait_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    data_nxt  = data_r;
    rd_nxt    = rd_r;
    abort_nxt = abort_r;
    done      = 1'b0;
    err       = 1'b0;
    rvalid    = 1'b0;
    rlast     = 1'b0;
    rbyte     = 8'd0;
    if (go) begin
      if (phase_r == i2cm_pkg::PH_IDLE) begin
        // new transaction
        if (item.cmd != i2cm_pkg::CMD_TICK) begin
          dev_nxt   = item.dev_addr;
          reg_nxt   = item.reg_addr;
          data_nxt  = item.write_data;
          left_nxt  = item.read_count;
          rd_nxt    = (item.cmd == i2cm_pkg::CMD_READ);
          stage_nxt = i2cm_pkg::STG_DEV;
          abort_nxt = 1'b0;
          shift_nxt = item.dev_addr;
          bit_nxt   = 4'd0;
          phase_nxt = i2cm_pkg::PH_ST_HIGH;
          delay_nxt = half_eff;
        end
      end else if (delay_r > 16'd1) begin
        delay_nxt = delay_r - 16'd1;
      end else begin
        delay_nxt = half_eff;
        case (phase_r)
          i2cm_pkg::PH_ST_HIGH: phase_nxt = i2cm_pkg::PH_ST_LOW;
          i2cm_pkg::PH_ST_LOW: begin
            bit_nxt   = 4'd0;
            phase_nxt = i2cm_pkg::PH_TX_LO;
          end
          i2cm_pkg::PH_TX_LO: phase_nxt = i2cm_pkg::PH_TX_HI;
          i2cm_pkg::PH_TX_HI: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            if (bit_r >= 4'd7) begin
              wait_nxt  = 16'd0;
              phase_nxt = i2cm_pkg::PH_ACK_LO;
            end else begin
              phase_nxt = i2cm_pkg::PH_TX_LO;
            end
          end
          i2cm_pkg::PH_ACK_LO: phase_nxt = i2cm_pkg::PH_ACK_HI;
          i2cm_pkg::PH_ACK_HI: begin
            // poll every tick once the high phase has run
            delay_nxt = 16'd1;
            if (!item.sda_in) begin
              delay_nxt = half_eff;
              case (stage_r)
                i2cm_pkg::STG_DEV: begin
                  stage_nxt = i2cm_pkg::STG_REG;
                  shift_nxt = reg_r;
                  bit_nxt   = 4'd0;
                  phase_nxt = i2cm_pkg::PH_TX_LO;
                end
                i2cm_pkg::STG_REG: begin
                  stage_nxt = i2cm_pkg::STG_SECOND;
                  if (rd_r) begin
                    shift_nxt = dev_r + 8'd1;
                    phase_nxt = i2cm_pkg::PH_RS_PREP;
                  end else begin
                    shift_nxt = data_r;
                    bit_nxt   = 4'd0;
                    phase_nxt = i2cm_pkg::PH_TX_LO;
                  end
                end
                i2cm_pkg::STG_SECOND: begin
                  if (rd_r) begin
                    stage_nxt = i2cm_pkg::STG_RX;
                    shift_nxt = 8'd0;
                    bit_nxt   = 4'd0;
                    phase_nxt = i2cm_pkg::PH_RX_LO;
                  end else begin
                    phase_nxt = i2cm_pkg::PH_SP_LO;
                  end
                end
                default: phase_nxt = i2cm_pkg::PH_SP_LO;
              endcase
            end else begin
              wait_nxt = wait_inc;
              if (wait_inc >= ackto_r) begin
                abort_nxt = 1'b1;
                delay_nxt = half_eff;
                phase_nxt = i2cm_pkg::PH_SP_LO;
              end
            end
          end
          i2cm_pkg::PH_RS_PREP: phase_nxt = i2cm_pkg::PH_ST_HIGH;
          i2cm_pkg::PH_RX_LO:   phase_nxt = i2cm_pkg::PH_RX_HI;
          i2cm_pkg::PH_RX_HI: begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            bit_nxt   = bit_r + 4'd1;
            if (bit_r >= 4'd7) begin
              rvalid    = 1'b1;
              rbyte     = {shift_r[6:0], item.sda_in};
              rlast     = (left_r <= 8'd1);
              phase_nxt = i2cm_pkg::PH_MACK_LO;
            end else begin
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_MACK_LO: phase_nxt = i2cm_pkg::PH_MACK_HI;
          i2cm_pkg::PH_MACK_HI: begin
            if (left_r <= 8'd1) begin
              phase_nxt = i2cm_pkg::PH_SP_LO;
            end else begin
              left_nxt  = left_r - 8'd1;
              shift_nxt = 8'd0;
              bit_nxt   = 4'd0;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_SP_LO: phase_nxt = i2cm_pkg::PH_SP_HI;
          i2cm_pkg::PH_SP_HI: begin
            phase_nxt = i2cm_pkg::PH_IDLE;
            delay_nxt = 16'd0;
            done      = 1'b1;
            err       = abort_r;
            abort_nxt = 1'b0;
          end
          default: begin
            phase_nxt = i2cm_pkg::PH_IDLE;
            delay_nxt = delay_r;
          end
        endcase
      end
    end
  end

  // line levels for the phase being entered
  always_comb begin
    nack          = (left_nxt <= 8'd1);
    res.done_res  = done;
    res.error     = err;
    res.read_byte = rbyte;
    res.read_valid = rvalid;
    res.read_last = rlast;
    res.busy_res  = (phase_nxt != i2cm_pkg::PH_IDLE);
    case (phase_nxt)
      i2cm_pkg::PH_ST_HIGH: {res.scl, res.sda_out, res.sda_oe} = 3'b111;
      i2cm_pkg::PH_ST_LOW:  {res.scl, res.sda_out, res.sda_oe} = 3'b101;
      i2cm_pkg::PH_TX_LO:   {res.scl, res.sda_out, res.sda_oe} = {1'b0, shift_nxt[7], 1'b1};
      i2cm_pkg::PH_TX_HI:   {res.scl, res.sda_out, res.sda_oe} = {1'b1, shift_nxt[7], 1'b1};
      i2cm_pkg::PH_ACK_LO:  {res.scl, res.sda_out, res.sda_oe} = 3'b010;
      i2cm_pkg::PH_ACK_HI:  {res.scl, res.sda_out, res.sda_oe} = 3'b110;
      i2cm_pkg::PH_RS_PREP: {res.scl, res.sda_out, res.sda_oe} = 3'b011;
      i2cm_pkg::PH_RX_LO:   {res.scl, res.sda_out, res.sda_oe} = 3'b010;
      i2cm_pkg::PH_RX_HI:   {res.scl, res.sda_out, res.sda_oe} = 3'b110;
      i2cm_pkg::PH_MACK_LO: {res.scl, res.sda_out, res.sda_oe} = {1'b0, nack, 1'b1};
      i2cm_pkg::PH_MACK_HI: {res.scl, res.sda_out, res.sda_oe} = {1'b1, nack, 1'b1};
      i2cm_pkg::PH_SP_LO:   {res.scl, res.sda_out, res.sda_oe} = 3'b001;
      i2cm_pkg::PH_SP_HI:   {res.scl, res.sda_out, res.sda_oe} = 3'b111;
      default:              {res.scl, res.sda_out, res.sda_oe} = 3'b110;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cm_pkg::PH_IDLE;
      stage_r <= i2cm_pkg::STG_DEV;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      left_r  <= 8'd0;
      delay_r <= 16'd0;
      wait_r  <= 16'd0;
      dev_r   <= 8'd0;
      reg_r   <= 8'd0;
      data_r  <= 8'd0;
      rd_r    <= 1'b0;
      abort_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      delay_r <= delay_nxt;
      wait_r  <= wait_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      data_r  <= data_nxt;
      rd_r    <= rd_nxt;
      abort_r <= abort_nxt;
    end
  end

endmodule

// ===== rtl/core/i2cm_resq.sv =====
// ----------------------------------------------------------------------------
// i2cm_resq
// Result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module i2cm_resq #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cm_pkg::result_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output i2cm_pkg::result_t rdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  i2cm_pkg::result_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr_r];

endmodule

// ===== rtl/core/i2c_master_register_access.sv =====
// I2C master for single register writes and multi-byte register reads. Every
// request is one bus tick: it carries the sampled SDA level and optionally a
// write or read command, and yields exactly one result with the SCL/SDA drive
// for the next tick plus done, error and received-byte status. One request is
// taken per clock while the request queue holds one and the result queue is
// not full; each result is registered in the result queue before it shows on
// the result port. Requests and results pass through queues of QUEUE_DEPTH
// entries, so either side may stall on its own. Configuration (half period,
// ACK timeout) is to be written through cfg_* only while no transaction is in
// flight; the user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Top level: request queue, bus sequencer and result queue.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2c_master_register_access #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  // requests
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_dev_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_read_count,
  input  logic        in_sda_in,
  // results
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_sda_oe,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_error,
  output logic [7:0]  out_read_byte,
  output logic        out_read_valid,
  output logic        out_read_last
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::qctl_t   fq_ctl;
  i2cm_pkg::result_t res_w, res_r;
  logic              eng_pop, res_push, res_full;

  // request queue with classification
  i2cm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .opcode     (in_opcode),
    .dev_addr   (in_dev_addr),
    .reg_addr   (in_reg_addr),
    .write_data (in_write_data),
    .read_count (in_read_count),
    .sda_in     (in_sda_in),
    .item       (item),
    .ctl_out    (fq_ctl),
    .ctl_pop    (eng_pop)
  );

  // bus sequencer
  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctl_in    (fq_ctl),
    .pop       (eng_pop),
    .item      (item),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_w)
  );

  // result queue
  i2cm_resq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_r)
  );

  assign out_scl        = res_r.scl;
  assign out_sda_out    = res_r.sda_out;
  assign out_sda_oe     = res_r.sda_oe;
  assign out_busy_res   = res_r.busy_res;
  assign out_done_res   = res_r.done_res;
  assign out_error      = res_r.error;
  assign out_read_byte  = res_r.read_byte;
  assign out_read_valid = res_r.read_valid;
  assign out_read_last  = res_r.read_last;

  // checks
  `I2CM_ASSERT_NEXT(a_push_lands, clk, rst_n, in_push && !in_full, fq_ctl.valid, "accepted request lost")
  `I2CM_ASSERT_IMPL(a_done_not_busy, clk, rst_n, !out_empty && out_done_res, !out_busy_res, "done while busy")
  `I2CM_ASSERT_IMPL(a_error_with_done, clk, rst_n, !out_empty && out_error, out_done_res, "error without done")
  `I2CM_ASSERT_IMPL(a_released_high, clk, rst_n, !out_empty && !out_sda_oe, out_sda_out, "released SDA not high")

endmodule
